// ----- hw/rtl/mkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, result kinds, character codes and the two-pair letter table.
// ----------------------------------------------------------------------------
`default_nettype none

package mkd_pkg;

	// widths of the fixed fields
	localparam int LIMIT_W = 16;
	localparam int CHAR_W  = 7;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 2;

	// symbols stored per letter
	localparam int MAX_SYMBOLS = 4;
	localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);

	// register reset values
	localparam logic [LIMIT_W-1:0] DASH_LIMIT_RST = 16'd1000;
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 16'd12288;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DOT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DASH   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LETTER = 2'd2;

	// echo characters
	localparam logic [CHAR_W-1:0] CH_DOT  = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_DASH = 7'h5F;

	typedef logic [2:0] pair_t;

	// row and column are each the code of one pair of symbol slots
	localparam logic [CHAR_W-1:0] LETTER_TABLE [7][7] = '{
		'{7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h45},
		'{7'h53, 7'h48, 7'h46, 7'h56, 7'h3F, 7'h55, 7'h49},
		'{7'h44, 7'h42, 7'h43, 7'h58, 7'h59, 7'h4B, 7'h4E},
		'{7'h52, 7'h4C, 7'h50, 7'h3F, 7'h4A, 7'h57, 7'h41},
		'{7'h47, 7'h5A, 7'h3F, 7'h51, 7'h3F, 7'h4F, 7'h4D},
		'{7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h54},
		'{7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F}
	};

	// code of a pair of slots from presence and dash flags
	function automatic pair_t pair_code(input logic have_a, input logic have_b,
			input logic dash_a, input logic dash_b);
		pair_t code;
		if (!have_a) begin
			code = 3'd6;
		end else if (!have_b) begin
			code = dash_a ? 3'd5 : 3'd0;
		end else if (!dash_a) begin
			code = dash_b ? 3'd3 : 3'd1;
		end else begin
			code = dash_b ? 3'd4 : 3'd2;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/morse_key_decoder.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder
// Turns one sampled key level per tick into dot/dash echoes and letters.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one key level per tick in s_tdata[0]. Each accepted request
//   updates the timers and symbol store; a result (dot echo, dash echo or
//   decoded letter) is registered into the output stage and shown on m_*,
//   with the kind on m_tuser and the character on m_tdata.
//   Throughput is one request per cycle while s_tready is high: a two-entry
//   output stage (result register plus skid register) lets a new request in
//   while a result waits. s_tready drops only when both entries hold results
//   the receiver has not taken; no result is ever lost or repeated.
//   cfg_we writes dash_limit (index 0) or idle_limit (index 1) from cfg_data;
//   other indexes are ignored. A limit of zero acts as one.
//   Reset (arst_n low) clears the phase, timers, symbol store and output
//   stage and loads the limits with 1000 and 12288.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_key_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// key level input
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [0] key_level
	// result output
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata,   // [6:0] char_code
	output logic [mkd_pkg::KIND_W-1:0]         m_tuser,   // [1:0] kind
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mkd_pkg::LIMIT_W-1:0]   cfg_data
);
	import mkd_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PRESS = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;

	logic [LIMIT_W-1:0]   dash_limit_q, idle_limit_q;
	logic [1:0]           phase_q, phase_n;
	logic [LIMIT_W-1:0]   tick_q, tick_n, tick_inc;
	logic [SYM_CNT_W-1:0] sym_cnt_q, sym_cnt_n;
	logic [MAX_SYMBOLS-1:0] sym_bits_q, sym_bits_n;
	logic [LIMIT_W-1:0]   dash_eff, idle_eff;

	logic                 key;
	logic                 take;
	logic                 res_v;
	logic [KIND_W-1:0]    res_kind;
	logic [CHAR_W-1:0]    res_char;
	pair_t                row, col;

	logic                 head_v_q, skid_v_q;
	logic [KIND_W-1:0]    head_kind_q, skid_kind_q;
	logic [CHAR_W-1:0]    head_char_q, skid_char_q;
	logic                 pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_limit_q <= DASH_LIMIT_RST;
			idle_limit_q <= IDLE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DASH_LIMIT: dash_limit_q <= cfg_data;
				REG_IDLE_LIMIT: idle_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero limits behave as one
	assign dash_eff = (dash_limit_q == '0) ? LIMIT_W'(1) : dash_limit_q;
	assign idle_eff = (idle_limit_q == '0) ? LIMIT_W'(1) : idle_limit_q;

	assign key      = s_tdata[0];
	assign take     = s_tvalid && s_tready;
	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + LIMIT_W'(1);

	// letter lookup from the first and second pair of slots
	assign row = pair_code(sym_cnt_q > SYM_CNT_W'(0), sym_cnt_q > SYM_CNT_W'(1),
		sym_bits_q[0], sym_bits_q[1]);
	assign col = pair_code(sym_cnt_q > SYM_CNT_W'(2), sym_cnt_q > SYM_CNT_W'(3),
		sym_bits_q[2], sym_bits_q[3]);

	// next state and result for one key level
	always_comb begin
		phase_n    = phase_q;
		tick_n     = tick_q;
		sym_cnt_n  = sym_cnt_q;
		sym_bits_n = sym_bits_q;
		res_v      = 1'b0;
		res_kind   = KIND_DOT;
		res_char   = CH_DOT;
		case (phase_q)
			PH_PRESS: begin
				tick_n = tick_inc;
				if (tick_inc >= dash_eff) begin
					tick_n = '0;
					if (sym_cnt_q < SYM_CNT_W'(MAX_SYMBOLS)) begin
						sym_bits_n[sym_cnt_q[SYM_IDX_W-1:0]] = key;
						sym_cnt_n = sym_cnt_q + SYM_CNT_W'(1);
					end
					res_v = 1'b1;
					if (key) begin
						phase_n  = PH_HOLD;
						res_kind = KIND_DASH;
						res_char = CH_DASH;
					end else begin
						phase_n  = PH_IDLE;
					end
				end
			end
			PH_HOLD: begin
				if (!key) begin
					phase_n = PH_IDLE;
					tick_n  = '0;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (key) begin
					phase_n = PH_PRESS;
					tick_n  = '0;
				end else begin
					tick_n = tick_inc;
					if (tick_inc >= idle_eff) begin
						tick_n = '0;
						if (sym_cnt_q != '0) begin
							res_v      = 1'b1;
							res_kind   = KIND_LETTER;
							res_char   = LETTER_TABLE[row][col];
							sym_cnt_n  = '0;
							sym_bits_n = '0;
						end
					end
				end
			end
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			sym_cnt_q  <= '0;
			sym_bits_q <= '0;
		end else if (take) begin
			phase_q    <= phase_n;
			tick_q     <= tick_n;
			sym_cnt_q  <= sym_cnt_n;
			sym_bits_q <= sym_bits_n;
		end
	end

	// output stage: result register with skid entry
	assign pop      = head_v_q && m_tready;
	assign s_tready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					head_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					head_v_q <= take && res_v;
				end
			end else if (take && res_v) begin
				if (head_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					head_v_q <= 1'b1;
				end
			end
		end
	end

	// payload of the output stage
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_kind_q <= skid_kind_q;
				head_char_q <= skid_char_q;
			end else begin
				head_kind_q <= res_kind;
				head_char_q <= res_char;
			end
		end else if (take && res_v) begin
			if (head_v_q) begin
				skid_kind_q <= res_kind;
				skid_char_q <= res_char;
			end else begin
				head_kind_q <= res_kind;
				head_char_q <= res_char;
			end
		end
	end

	assign m_tvalid = head_v_q;
	assign m_tdata  = {1'b0, head_char_q};
	assign m_tuser  = head_kind_q;

endmodule

`default_nettype wire
